// File: design/pfat_pkg.sv
`default_nettype none
package pfat_pkg;

	localparam int NUM_FRAMES_DEF  = 64;
	localparam int OFFSET_BITS_DEF = 8;
	localparam int VADDR_BITS_DEF  = 16;

	localparam int PID_W  = 8;
	localparam int ADDR_W = 16;
	localparam int SIZE_W = 16;
	localparam int DATA_W = 8;
	localparam int PID_SLOTS = 256;

	// Action codes of an input item.
	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	localparam logic [1:0] ACT_WRITE = 2'd3;

	// Write commands from the sequencer to the frame table.
	typedef struct packed {
		logic claim;
		logic release_frame;
		logic link;
	} ft_ctl_t;

endpackage
`default_nettype wire

// File: design/pfat_frame_table.sv
`default_nettype none
module pfat_frame_table #(
	parameter int NUM_FRAMES  = pfat_pkg::NUM_FRAMES_DEF,
	parameter int OFFSET_BITS = pfat_pkg::OFFSET_BITS_DEF,
	parameter int VADDR_BITS  = pfat_pkg::VADDR_BITS_DEF,
	localparam int FW   = $clog2(NUM_FRAMES),
	localparam int VP_W = (VADDR_BITS > OFFSET_BITS) ? VADDR_BITS - OFFSET_BITS : 1
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  pfat_pkg::ft_ctl_t          ctl,
	input  wire  [FW-1:0]              rd_idx,
	input  wire  [FW-1:0]              wr_idx,
	input  wire  [pfat_pkg::PID_W-1:0] wr_owner,
	input  wire  [VP_W-1:0]            wr_vpage,
	input  wire  [FW-1:0]              link_idx,
	input  wire  [FW:0]                link_val,
	output logic [pfat_pkg::PID_W-1:0] rd_owner,
	output logic [VP_W-1:0]            rd_vpage,
	output logic [FW:0]                rd_next,
	output logic [NUM_FRAMES-1:0]      valid
);
	logic [pfat_pkg::PID_W-1:0] owner_mem [NUM_FRAMES];
	logic [VP_W-1:0]            vpage_mem [NUM_FRAMES];
	logic [FW:0]                next_mem  [NUM_FRAMES];
	logic [NUM_FRAMES-1:0]      valid_q;

	assign valid = valid_q;

	// A frame whose valid bit is clear is free, whatever its owner entry holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.claim) begin
			valid_q[wr_idx] <= 1'b1;
		end else if (ctl.release_frame) begin
			valid_q[wr_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.claim) begin
			owner_mem[wr_idx] <= wr_owner;
			vpage_mem[wr_idx] <= wr_vpage;
		end
		if (ctl.link) begin
			next_mem[link_idx] <= link_val;
		end
		rd_owner <= owner_mem[rd_idx];
		rd_vpage <= vpage_mem[rd_idx];
		rd_next  <= next_mem[rd_idx];
	end

endmodule
`default_nettype wire

// File: design/pfat_byte_store.sv
`default_nettype none
module pfat_byte_store #(
	parameter int NUM_FRAMES  = pfat_pkg::NUM_FRAMES_DEF,
	parameter int OFFSET_BITS = pfat_pkg::OFFSET_BITS_DEF,
	localparam int FW   = $clog2(NUM_FRAMES),
	localparam int BA_W = FW + OFFSET_BITS
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         we,
	input  wire  [BA_W-1:0]             addr,
	input  wire  [pfat_pkg::DATA_W-1:0] wdata,
	output logic [pfat_pkg::DATA_W-1:0] rdata,
	output logic                        clearing
);
	localparam int DEPTH = NUM_FRAMES << OFFSET_BITS;

	logic [pfat_pkg::DATA_W-1:0] mem [DEPTH];
	logic [BA_W-1:0]             clr_q;
	logic                        clearing_q;

	assign clearing = clearing_q;

	// After reset the whole store is swept to zero, one byte per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + BA_W'(1);
			if (clr_q == BA_W'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_q] <= '0;
		end else if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

// File: design/paged_frame_allocator_translator_unit.sv
`default_nettype none
// Paged frame allocator and translator. An item is taken when start is high and busy is
// low; its single result appears on status, read_data and base_address for exactly one
// cycle with done high, and the receiver cannot hold it off. All work runs through one
// frame table scanned one entry per cycle by a small sequencer. A write or a read looks up
// its page in a lookup scan of the frame table, and a read then fetches the byte; a free
// runs the lookup and then walks the chain through the next-pointer memory, releasing each
// frame that the pid owns; an allocate claims free frames in a claim scan of the free bits.
// After reset the block is busy while the byte memory of NUM_FRAMES << OFFSET_BITS bytes
// is cleared.
module paged_frame_allocator_translator_unit #(
	parameter int NUM_FRAMES  = pfat_pkg::NUM_FRAMES_DEF,
	parameter int OFFSET_BITS = pfat_pkg::OFFSET_BITS_DEF,
	parameter int VADDR_BITS  = pfat_pkg::VADDR_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	output logic                        busy,
	input  wire  [1:0]                  action,
	input  wire  [pfat_pkg::PID_W-1:0]  pid,
	input  wire  [pfat_pkg::ADDR_W-1:0] address,
	input  wire  [pfat_pkg::SIZE_W-1:0] size,
	input  wire  [pfat_pkg::DATA_W-1:0] write_data,
	output logic                        done,
	output logic                        status,
	output logic [pfat_pkg::DATA_W-1:0] read_data,
	output logic [pfat_pkg::ADDR_W-1:0] base_address
);
	localparam int FW     = $clog2(NUM_FRAMES);
	localparam int NW     = FW + 1;
	localparam int VP_W   = (VADDR_BITS > OFFSET_BITS) ? VADDR_BITS - OFFSET_BITS : 1;
	localparam int CW     = $clog2(NUM_FRAMES + 1);
	localparam int PG_W   = 17 - OFFSET_BITS;
	localparam int BRK_W  = VADDR_BITS + 1;
	localparam int SUM_W  = ((BRK_W > 17) ? BRK_W : 17) + 1;
	localparam int BA_W   = FW + OFFSET_BITS;
	localparam int PAGE   = 1 << OFFSET_BITS;
	localparam logic [NW-1:0] CHAIN_END = NW'(2 * NUM_FRAMES - 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_BYTE, S_ACHK, S_CLAIM, S_AEND, S_FRD, S_FCHK
	} state_t;

	state_t                      state_q;
	logic [1:0]                  action_q;
	logic [pfat_pkg::PID_W-1:0]  pid_q;
	logic [pfat_pkg::ADDR_W-1:0] addr_q;
	logic [pfat_pkg::SIZE_W-1:0] size_q;
	logic [pfat_pkg::DATA_W-1:0] wdata_q;
	logic [FW-1:0]               scan_q;
	logic                        scan_done_q;
	logic                        scan_s1;
	logic [FW-1:0]               idx_s1;
	logic [CW-1:0]               free_cnt_q;
	logic [PG_W-1:0]             taken_q;
	logic [NW-1:0]               prev_q;
	logic [VP_W-1:0]             vp_q;
	logic [pfat_pkg::ADDR_W-1:0] base_hold_q;
	logic [NW-1:0]               walk_q;
	logic [NW-1:0]               steps_q;
	logic                        done_q;
	logic                        status_q;
	logic [pfat_pkg::DATA_W-1:0] rdata_q;
	logic [pfat_pkg::ADDR_W-1:0] base_q;

	logic [BRK_W-1:0]            brk_mem [pfat_pkg::PID_SLOTS];
	logic [pfat_pkg::PID_SLOTS-1:0] brk_vld_q;
	logic [BRK_W-1:0]            brk_rd_s1;
	logic                        brk_rd_vld_s1;
	logic [pfat_pkg::PID_W-1:0]  brk_raddr;
	logic                        brk_we;

	pfat_pkg::ft_ctl_t           ft_ctl;
	logic [FW-1:0]               ft_rd_idx;
	logic [FW-1:0]               ft_wr_idx;
	logic [NW-1:0]               ft_link_val;
	logic [pfat_pkg::PID_W-1:0]  ft_owner;
	logic [VP_W-1:0]             ft_vpage;
	logic [NW-1:0]               ft_next;
	logic [NUM_FRAMES-1:0]       ft_valid;

	logic                        bs_we;
	logic [BA_W-1:0]             bs_addr;
	logic [pfat_pkg::DATA_W-1:0] bs_rdata;
	logic                        clearing;

	logic                        accept;
	logic [VP_W-1:0]             addr_vp;
	logic                        addr_bad;
	logic                        match;
	logic                        hit;
	logic                        miss;
	logic [16:0]                 round_sum;
	logic [PG_W-1:0]             pages;
	logic [16:0]                 rnd_bytes;
	logic [BRK_W-1:0]            brk_val;
	logic [SUM_W-1:0]            brk_sum;
	logic                        alloc_fail;
	logic                        claim_here;
	logic                        walk_end;
	logic                        walk_own;

	assign busy         = (state_q != S_IDLE) || clearing;
	assign accept       = start && !busy;
	assign done         = done_q;
	assign status       = status_q;
	assign read_data    = rdata_q;
	assign base_address = base_q;

	always_comb begin
		addr_vp   = VP_W'(addr_q >> OFFSET_BITS);
		addr_bad  = (pid_q == '0) || (({16'd0, addr_q} >> VADDR_BITS) != 32'd0);
		match     = ft_valid[idx_s1] && (ft_owner == pid_q) && (ft_vpage == addr_vp);
		hit       = scan_s1 && match && !addr_bad;
		miss      = !hit && (addr_bad || (scan_s1 && idx_s1 == FW'(NUM_FRAMES - 1)));
		round_sum = 17'(size_q) + 17'(PAGE - 1);
		pages     = PG_W'(round_sum >> OFFSET_BITS);
		rnd_bytes = round_sum & ~17'(PAGE - 1);
		brk_val   = brk_rd_vld_s1 ? brk_rd_s1 : '0;
		brk_sum   = SUM_W'(brk_val) + SUM_W'(rnd_bytes);
		alloc_fail = (pid_q == '0) || (size_q == '0)
			|| (17'(free_cnt_q) < 17'(pages))
			|| (brk_sum > (SUM_W'(1) << VADDR_BITS));
		claim_here = !ft_valid[scan_q];
		walk_end   = walk_q >= NW'(NUM_FRAMES);
		walk_own   = ft_valid[walk_q[FW-1:0]] && (ft_owner == pid_q);
	end

	// Frame table and store commands follow the sequencer state.
	always_comb begin
		ft_ctl        = '0;
		ft_rd_idx     = (state_q == S_SCAN) ? scan_q : walk_q[FW-1:0];
		ft_wr_idx     = (state_q == S_CLAIM) ? scan_q : walk_q[FW-1:0];
		ft_link_val   = (state_q == S_AEND) ? CHAIN_END : NW'(scan_q);
		bs_addr       = {idx_s1, addr_q[OFFSET_BITS-1:0]};
		bs_we         = (state_q == S_SCAN) && hit && (action_q == pfat_pkg::ACT_WRITE);
		brk_raddr     = (state_q == S_IDLE) ? pid : pid_q;
		brk_we        = (state_q == S_ACHK) && !alloc_fail;
		unique case (state_q)
			S_CLAIM: begin
				ft_ctl.claim = claim_here;
				ft_ctl.link  = claim_here && (prev_q != CHAIN_END);
			end
			S_AEND: begin
				ft_ctl.link = 1'b1;
			end
			S_FCHK: begin
				ft_ctl.release_frame = walk_own;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (brk_we) begin
			brk_mem[pid_q] <= BRK_W'(brk_sum);
		end
		brk_rd_s1 <= brk_mem[brk_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brk_vld_q     <= '0;
			brk_rd_vld_s1 <= 1'b0;
		end else begin
			if (brk_we) begin
				brk_vld_q[pid_q] <= 1'b1;
			end
			brk_rd_vld_s1 <= brk_vld_q[brk_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			action_q    <= '0;
			pid_q       <= '0;
			addr_q      <= '0;
			size_q      <= '0;
			wdata_q     <= '0;
			scan_q      <= '0;
			scan_done_q <= 1'b0;
			scan_s1     <= 1'b0;
			idx_s1      <= '0;
			free_cnt_q  <= CW'(NUM_FRAMES);
			taken_q     <= '0;
			prev_q      <= CHAIN_END;
			vp_q        <= '0;
			base_hold_q <= '0;
			walk_q      <= '0;
			steps_q     <= '0;
			done_q      <= 1'b0;
			status_q    <= 1'b0;
			rdata_q     <= '0;
			base_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						action_q    <= action;
						pid_q       <= pid;
						addr_q      <= address;
						size_q      <= size;
						wdata_q     <= write_data;
						scan_q      <= '0;
						scan_done_q <= 1'b0;
						scan_s1     <= 1'b0;
						state_q     <= (action == pfat_pkg::ACT_ALLOC) ? S_ACHK : S_SCAN;
					end
				end
				S_SCAN: begin
					scan_s1     <= !scan_done_q;
					idx_s1      <= scan_q;
					scan_q      <= scan_q + FW'(1);
					scan_done_q <= scan_done_q || (scan_q == FW'(NUM_FRAMES - 1));
					if (hit) begin
						priority if (action_q == pfat_pkg::ACT_FREE) begin
							walk_q  <= NW'(idx_s1);
							steps_q <= '0;
							state_q <= S_FRD;
						end else if (action_q == pfat_pkg::ACT_READ) begin
							state_q <= S_BYTE;
						end else begin
							done_q   <= 1'b1;
							status_q <= 1'b0;
							rdata_q  <= '0;
							base_q   <= '0;
							state_q  <= S_IDLE;
						end
					end else if (miss) begin
						done_q   <= 1'b1;
						status_q <= (action_q != pfat_pkg::ACT_FREE);
						rdata_q  <= '0;
						base_q   <= '0;
						state_q  <= S_IDLE;
					end
				end
				S_BYTE: begin
					done_q   <= 1'b1;
					status_q <= 1'b0;
					rdata_q  <= bs_rdata;
					base_q   <= '0;
					state_q  <= S_IDLE;
				end
				S_ACHK: begin
					if (alloc_fail) begin
						done_q   <= 1'b1;
						status_q <= 1'b1;
						rdata_q  <= '0;
						base_q   <= '0;
						state_q  <= S_IDLE;
					end else begin
						free_cnt_q  <= free_cnt_q - CW'(pages);
						base_hold_q <= pfat_pkg::ADDR_W'(brk_val);
						vp_q        <= VP_W'(brk_val >> OFFSET_BITS);
						taken_q     <= '0;
						prev_q      <= CHAIN_END;
						scan_q      <= '0;
						state_q     <= S_CLAIM;
					end
				end
				S_CLAIM: begin
					scan_q <= scan_q + FW'(1);
					if (claim_here) begin
						prev_q  <= NW'(scan_q);
						vp_q    <= vp_q + VP_W'(1);
						taken_q <= taken_q + PG_W'(1);
						if (taken_q == pages - PG_W'(1)) begin
							state_q <= S_AEND;
						end
					end
				end
				S_AEND: begin
					done_q   <= 1'b1;
					status_q <= 1'b0;
					rdata_q  <= '0;
					base_q   <= base_hold_q;
					state_q  <= S_IDLE;
				end
				S_FRD: begin
					if (walk_end) begin
						done_q   <= 1'b1;
						status_q <= 1'b0;
						rdata_q  <= '0;
						base_q   <= '0;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_FCHK;
					end
				end
				S_FCHK: begin
					if (walk_own && steps_q != NW'(NUM_FRAMES - 1)) begin
						free_cnt_q <= free_cnt_q + CW'(1);
						walk_q     <= ft_next;
						steps_q    <= steps_q + NW'(1);
						state_q    <= S_FRD;
					end else begin
						if (walk_own) begin
							free_cnt_q <= free_cnt_q + CW'(1);
						end
						done_q   <= 1'b1;
						status_q <= 1'b0;
						rdata_q  <= '0;
						base_q   <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	pfat_frame_table #(
		.NUM_FRAMES (NUM_FRAMES),
		.OFFSET_BITS(OFFSET_BITS),
		.VADDR_BITS (VADDR_BITS)
	) u_frame_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ft_ctl),
		.rd_idx  (ft_rd_idx),
		.wr_idx  (ft_wr_idx),
		.wr_owner(pid_q),
		.wr_vpage(vp_q),
		.link_idx(prev_q[FW-1:0]),
		.link_val(ft_link_val),
		.rd_owner(ft_owner),
		.rd_vpage(ft_vpage),
		.rd_next (ft_next),
		.valid   (ft_valid)
	);

	pfat_byte_store #(
		.NUM_FRAMES (NUM_FRAMES),
		.OFFSET_BITS(OFFSET_BITS)
	) u_byte_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (bs_we),
		.addr    (bs_addr),
		.wdata   (wdata_q),
		.rdata   (bs_rdata),
		.clearing(clearing)
	);

endmodule
`default_nettype wire
